[src/assert_macros.svh]
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_IMPLY_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/clcd_pkg.sv]
// shared types, constants and strobe tables for the character lcd sequencer
package clcd_pkg;

   localparam int INIT_PASSES_DEFAULT = 2;
   localparam int INIT_STEPS = 14;

   typedef enum logic [2:0] {
      CMD_INIT       = 3'd0,
      CMD_CLEAR      = 3'd1,
      CMD_CURSOR_ON  = 3'd2,
      CMD_CURSOR_OFF = 3'd3,
      CMD_GOTO       = 3'd4,
      CMD_PUT_CHAR   = 3'd5
   } cmd_type;

   typedef enum logic [0:0] {
      CSR_ROW_COUNT    = 1'b0,
      CSR_COLUMN_COUNT = 1'b1
   } csr_index_type;

   localparam logic [2:0] ROWS_1 = 3'd1;
   localparam logic [2:0] ROWS_2 = 3'd2;
   localparam logic [2:0] ROWS_4 = 3'd4;

   localparam logic [2:0] ROW_COUNT_RESET    = 3'd2;
   localparam logic [5:0] COLUMN_COUNT_RESET = 6'd16;

   localparam logic [7:0] BYTE_CLEAR      = 8'h01;
   localparam logic [7:0] BYTE_CURSOR_ON  = 8'h0E;
   localparam logic [7:0] BYTE_CURSOR_OFF = 8'h0C;
   localparam logic [7:0] ADDRESS_CMD     = 8'h80;
   localparam logic [7:0] ROW1_OFFSET     = 8'h40;

   localparam logic [5:0] WRAP_COLUMN_4ROW = 6'd20;
   localparam logic [5:0] WRAP_COLUMN      = 6'd40;
   localparam logic [1:0] CLEAR_OWED_MS    = 2'd3;
   localparam logic [3:0] INIT_STEP_LAST   = 4'(INIT_STEPS - 1);

   typedef struct packed {
      logic       wait_busy;
      logic [6:0] wait_ms;
      logic       reg_select;
      logic [3:0] nibble;
   } strobe_type;

   typedef struct packed {
      logic       is_init;
      logic       two_bytes;
      logic       owe_delay;
      logic       rs_a;
      logic [7:0] byte_a;
      logic [7:0] byte_b;
   } job_type;

   // one pass of the wake-up and setup sequence
   function automatic strobe_type init_strobe(logic [3:0] step);
      strobe_type s;
      s.reg_select = 1'b0;
      case (step)
         4'd0: begin s.wait_busy = 1'b0; s.wait_ms = 7'd100; s.nibble = 4'h3; end
         4'd1: begin s.wait_busy = 1'b0; s.wait_ms = 7'd5;   s.nibble = 4'h3; end
         4'd2: begin s.wait_busy = 1'b0; s.wait_ms = 7'd1;   s.nibble = 4'h3; end
         4'd3: begin s.wait_busy = 1'b0; s.wait_ms = 7'd1;   s.nibble = 4'h2; end
         4'd4: begin s.wait_busy = 1'b0; s.wait_ms = 7'd1;   s.nibble = 4'h2; end
         4'd5: begin s.wait_busy = 1'b0; s.wait_ms = 7'd0;   s.nibble = 4'h8; end
         4'd6: begin s.wait_busy = 1'b1; s.wait_ms = 7'd0;   s.nibble = 4'h0; end
         4'd7: begin s.wait_busy = 1'b0; s.wait_ms = 7'd0;   s.nibble = 4'h8; end
         4'd8: begin s.wait_busy = 1'b1; s.wait_ms = 7'd0;   s.nibble = 4'h0; end
         4'd9: begin s.wait_busy = 1'b0; s.wait_ms = 7'd0;   s.nibble = 4'h1; end
         4'd10: begin s.wait_busy = 1'b1; s.wait_ms = 7'd3;  s.nibble = 4'h0; end
         4'd11: begin s.wait_busy = 1'b0; s.wait_ms = 7'd0;  s.nibble = 4'h6; end
         4'd12: begin s.wait_busy = 1'b1; s.wait_ms = 7'd0;  s.nibble = 4'h0; end
         4'd13: begin s.wait_busy = 1'b0; s.wait_ms = 7'd0;  s.nibble = 4'hF; end
         default: begin s.wait_busy = 1'b0; s.wait_ms = 7'd0; s.nibble = 4'h0; end
      endcase
      return s;
   endfunction

   // address instruction byte for a row and column
   function automatic logic [7:0] goto_byte(logic [5:0] col, logic [1:0] row,
                                            logic [2:0] rows, logic [5:0] cols);
      logic [7:0] offset;
      offset = 8'h00;
      if (rows == ROWS_2) begin
         if (row != 2'd0) offset = ROW1_OFFSET;
      end else if (rows == ROWS_4) begin
         case (row)
            2'd1: offset = ROW1_OFFSET;
            2'd2: offset = {2'b00, cols};
            2'd3: offset = ROW1_OFFSET + {2'b00, cols};
            default: offset = 8'h00;
         endcase
      end
      return ADDRESS_CMD | ({2'b00, col} + offset);
   endfunction

endpackage

[src/clcd_cursor.sv]
// command decode and cursor image tracking
module clcd_cursor (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [2:0]           cmd,
   input  logic [5:0]           column,
   input  logic [1:0]           row,
   input  logic [7:0]           char_code,
   input  logic [2:0]           row_count,
   input  logic [5:0]           column_count,
   output logic                 job_valid,
   output clcd_pkg::job_type    job
);

   logic [1:0] cursor_row_ff, cursor_row_in;
   logic [5:0] cursor_column_ff, cursor_column_in;
   logic [5:0] col_inc;
   logic [1:0] row_next;
   logic [5:0] col_next;

   always_comb begin
      col_inc   = cursor_column_ff + 6'd1;
      row_next  = cursor_row_ff;
      col_next  = cursor_column_ff;
      job_valid = 1'b1;
      job.is_init   = 1'b0;
      job.two_bytes = 1'b0;
      job.owe_delay = 1'b0;
      job.rs_a      = 1'b0;
      job.byte_a    = 8'h00;
      job.byte_b    = 8'h00;
      case (clcd_pkg::cmd_type'(cmd))
         clcd_pkg::CMD_INIT: begin
            job.is_init = 1'b1;
            row_next    = 2'd0;
            col_next    = 6'd0;
         end
         clcd_pkg::CMD_CLEAR: begin
            job.byte_a    = clcd_pkg::BYTE_CLEAR;
            job.owe_delay = 1'b1;
         end
         clcd_pkg::CMD_CURSOR_ON: begin
            job.byte_a = clcd_pkg::BYTE_CURSOR_ON;
         end
         clcd_pkg::CMD_CURSOR_OFF: begin
            job.byte_a = clcd_pkg::BYTE_CURSOR_OFF;
         end
         clcd_pkg::CMD_GOTO: begin
            job.byte_a = clcd_pkg::goto_byte(column, row, row_count, column_count);
            row_next   = row;
            col_next   = column;
         end
         clcd_pkg::CMD_PUT_CHAR: begin
            job.rs_a   = 1'b1;
            job.byte_a = char_code;
            col_next   = col_inc;
            if (row_count == clcd_pkg::ROWS_4) begin
               if (col_inc >= clcd_pkg::WRAP_COLUMN_4ROW) begin
                  row_next      = cursor_row_ff + 2'd1;
                  col_next      = 6'd0;
                  job.two_bytes = 1'b1;
               end
            end else if (row_count == clcd_pkg::ROWS_2) begin
               if (col_inc >= clcd_pkg::WRAP_COLUMN) begin
                  row_next      = (cursor_row_ff == 2'd0) ? 2'd1 : 2'd0;
                  col_next      = 6'd0;
                  job.two_bytes = 1'b1;
               end
            end else if (row_count == clcd_pkg::ROWS_1) begin
               if (col_inc >= clcd_pkg::WRAP_COLUMN) col_next = 6'd0;
               job.two_bytes = 1'b1;
            end
            job.byte_b = clcd_pkg::goto_byte(col_next, row_next, row_count, column_count);
         end
         default: begin
            job_valid = 1'b0;
         end
      endcase
      cursor_row_in    = accept ? row_next : cursor_row_ff;
      cursor_column_in = accept ? col_next : cursor_column_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_row_ff    <= 2'd0;
         cursor_column_ff <= 6'd0;
      end else begin
         cursor_row_ff    <= cursor_row_in;
         cursor_column_ff <= cursor_column_in;
      end
   end

endmodule

[src/char_lcd_4bit_command_sequencer.sv]
// top level: lcd command in, nibble strobes out
//
// channel | ports               | direction | moves
// req     | req_valid/req_ready | in        | one command item
// rsp     | rsp_valid/rsp_ready | out       | one nibble strobe item
// csr     | csr_we              | in        | register write, no wait
//
// a command is taken into the job register, then one strobe leaves per cycle
// through the output register: 2 strobes for most commands, 2 or 4 for put char,
// 14 * INIT_PASSES for init. the next command is taken in the cycle of the last
// strobe; rsp_ready low stalls the strobe counter. reset clears cursor, owed
// delay and both channels.
`include "assert_macros.svh"

module char_lcd_4bit_command_sequencer #(
   parameter int INIT_PASSES = clcd_pkg::INIT_PASSES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_cmd,
   input  logic [5:0] req_column,
   input  logic [1:0] req_row,
   input  logic [7:0] req_char_code,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_wait_busy,
   output logic [6:0] rsp_wait_ms,
   output logic       rsp_reg_select,
   output logic [3:0] rsp_nibble,
   output logic       rsp_last,
   input  logic       csr_we,
   input  logic [0:0] csr_index,
   input  logic [5:0] csr_wdata
);

   localparam int PASS_W = (INIT_PASSES > 1) ? $clog2(INIT_PASSES) : 1;
   localparam logic [PASS_W-1:0] PASS_LAST = PASS_W'(INIT_PASSES - 1);

   logic [2:0]            row_count_ff, row_count_in;
   logic [5:0]            column_count_ff, column_count_in;
   logic                  job_valid_ff, job_valid_in;
   clcd_pkg::job_type     job_ff, job_in;
   logic [3:0]            step_ff, step_in;
   logic [PASS_W-1:0]     pass_ff, pass_in;
   logic [1:0]            owed_ff, owed_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   clcd_pkg::strobe_type  rsp_ff, rsp_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  accept;
   logic                  emit;
   logic                  job_last;
   logic                  dec_valid;
   clcd_pkg::job_type     dec_job;
   clcd_pkg::strobe_type  strobe;
   logic [7:0]            cur_byte;

   clcd_cursor u_cursor (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .cmd          (req_cmd),
      .column       (req_column),
      .row          (req_row),
      .char_code    (req_char_code),
      .row_count    (row_count_ff),
      .column_count (column_count_ff),
      .job_valid    (dec_valid),
      .job          (dec_job)
   );

   // strobe selection for the current step
   always_comb begin
      cur_byte = step_ff[1] ? job_ff.byte_b : job_ff.byte_a;
      if (job_ff.is_init) begin
         strobe   = clcd_pkg::init_strobe(step_ff);
         job_last = (step_ff == clcd_pkg::INIT_STEP_LAST) && (pass_ff == PASS_LAST);
      end else begin
         strobe.wait_busy  = ~step_ff[0];
         strobe.wait_ms    = 7'd0;
         strobe.reg_select = step_ff[1] ? 1'b0 : job_ff.rs_a;
         strobe.nibble     = step_ff[0] ? cur_byte[3:0] : cur_byte[7:4];
         job_last          = step_ff[0] && (step_ff[1] == job_ff.two_bytes);
      end
   end

   assign emit      = job_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !job_valid_ff || (emit && job_last);
   assign accept    = req_valid && req_ready;

   always_comb begin
      row_count_in    = row_count_ff;
      column_count_in = column_count_ff;
      if (csr_we) begin
         case (clcd_pkg::csr_index_type'(csr_index))
            clcd_pkg::CSR_ROW_COUNT:    row_count_in    = csr_wdata[2:0];
            clcd_pkg::CSR_COLUMN_COUNT: column_count_in = csr_wdata;
            default: ;
         endcase
      end

      job_valid_in = job_valid_ff;
      job_in       = job_ff;
      step_in      = step_ff;
      pass_in      = pass_ff;
      if (accept) begin
         job_valid_in = dec_valid;
         job_in       = dec_job;
         step_in      = 4'd0;
         pass_in      = '0;
      end else if (emit) begin
         if (job_last) begin
            job_valid_in = 1'b0;
         end else if (job_ff.is_init && step_ff == clcd_pkg::INIT_STEP_LAST) begin
            step_in = 4'd0;
            pass_in = pass_ff + PASS_W'(1);
         end else begin
            step_in = step_ff + 4'd1;
         end
      end

      // a clear owes its settle time to whatever strobe comes next
      owed_in      = owed_ff;
      rsp_in       = rsp_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit) begin
         rsp_valid_in   = 1'b1;
         rsp_in         = strobe;
         rsp_in.wait_ms = (strobe.wait_ms > {5'd0, owed_ff}) ? strobe.wait_ms
                                                             : {5'd0, owed_ff};
         rsp_last_in    = job_last;
         owed_in        = (job_last && job_ff.owe_delay) ? clcd_pkg::CLEAR_OWED_MS : 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= clcd_pkg::ROW_COUNT_RESET;
         column_count_ff <= clcd_pkg::COLUMN_COUNT_RESET;
         job_valid_ff    <= 1'b0;
         step_ff         <= 4'd0;
         pass_ff         <= '0;
         owed_ff         <= 2'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         row_count_ff    <= row_count_in;
         column_count_ff <= column_count_in;
         job_valid_ff    <= job_valid_in;
         step_ff         <= step_in;
         pass_ff         <= pass_in;
         owed_ff         <= owed_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_wait_busy  = rsp_ff.wait_busy;
   assign rsp_wait_ms    = rsp_ff.wait_ms;
   assign rsp_reg_select = rsp_ff.reg_select;
   assign rsp_nibble     = rsp_ff.nibble;
   assign rsp_last       = rsp_last_ff;

   `ASSERT_IMPLY(a_take_on_last, clock, reset, accept && job_valid_ff, emit && job_last, "item taken before previous finished")
   `ASSERT_IMPLY(a_byte_step_range, clock, reset, job_valid_ff && !job_ff.is_init, step_ff[3:2] == 2'd0, "byte job step out of range")
   `ASSERT_IMPLY_NEXT(a_last_lands, clock, reset, emit && job_last, rsp_valid && rsp_last, "final strobe not registered")

endmodule
